FILE: design/fr4_pkg.sv
`default_nettype none
package fr4_pkg;
	localparam int OperandWidthDefault = 16;
	localparam int FieldWidth = 16;
	localparam int NumWidth = 32;
	localparam int DenWidth = 31;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_DEN_ZERO = 2'd1,
		ST_DIV_ZERO = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		EK_NORMAL = 2'd0,
		EK_DEN_ZERO = 2'd1,
		EK_DIV_ZERO = 2'd2,
		EK_ZERO = 2'd3
	} emit_kind_t;

	typedef enum logic [2:0] {
		DP_LOAD = 3'd0,
		DP_MUL = 3'd1,
		DP_SETUP = 3'd2,
		DP_GCD = 3'd3,
		DP_QUOT = 3'd4,
		DP_IDLE = 3'd5,
		DP_STEP = 3'd6,
		DP_QSTORE = 3'd7
	} dp_cmd_t;

	typedef struct packed {
		dp_cmd_t cmd;
		op_t op;
		logic div_start;
	} ctl_t;

	typedef struct packed {
		logic den_zero;
		logic div_zero;
		logic zero_num;
		logic gcd_done;
		logic div_busy;
	} sts_t;
endpackage
`default_nettype wire

FILE: design/fraction_four_op_reducer_core.sv
`default_nettype none
// Takes two signed fractions a/b and c/d as one input transaction and returns
// four reduced results in order: sum, difference, product and quotient, the
// last flagged by tlast; a zero input denominator gives one error result.
// One item at a time: each result runs Euclid's algorithm through a shared
// bit-serial divider, then two divisions by the GCD. A zero result skips the
// divisions and an error item skips the algorithm, so how long an item takes
// depends on data, plus any time the output is held off.
module fraction_four_op_reducer_core import fr4_pkg::*; #(
	parameter int OPERAND_WIDTH = OperandWidthDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// first_numerator, first_denominator, second_numerator, second_denominator
	input wire logic [63:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// result_numerator, result_denominator, zero fill to 64 bits
	output logic [63:0] m_axis_tdata,
	// operation, status, negative
	output logic [4:0] m_axis_tuser,
	output logic m_axis_tlast
);
	ctl_t ctl;
	sts_t sts;
	logic emit;
	emit_kind_t emit_kind;
	logic emit_last;
	logic negative;
	logic [NumWidth-1:0] res_num;
	logic [DenWidth-1:0] res_den;
	logic out_free;
	logic in_ready;

	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = in_ready;

	fr4_controller u_ctl (
		.clk(clk), .arst_n(arst_n), .in_fire(s_axis_tvalid && in_ready),
		.out_free(out_free), .sts(sts), .ctl(ctl), .in_ready(in_ready),
		.emit(emit), .emit_kind(emit_kind), .emit_last(emit_last)
	);

	fr4_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(s_axis_tdata), .ctl(ctl),
		.sts(sts), .negative(negative), .res_num(res_num), .res_den(res_den)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (emit) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_axis_tlast <= emit_last;
			unique case (emit_kind)
				EK_DEN_ZERO: begin
					m_axis_tuser <= {1'b0, ST_DEN_ZERO, OP_ADD};
					m_axis_tdata <= '0;
				end
				EK_DIV_ZERO: begin
					m_axis_tuser <= {1'b0, ST_DIV_ZERO, ctl.op};
					m_axis_tdata <= '0;
				end
				EK_ZERO: begin
					m_axis_tuser <= {1'b0, ST_OK, ctl.op};
					m_axis_tdata <= {1'b0, 31'd1, 32'd0};
				end
				default: begin
					m_axis_tuser <= {negative, ST_OK, ctl.op};
					m_axis_tdata <= {1'b0, res_den, res_num};
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast)))
		else $error("output changed while stalled");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[3:2] == ST_DEN_ZERO) |-> m_axis_tlast)
		else $error("error result not last");
	a_div_op: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[3:2] == ST_DIV_ZERO) |-> m_axis_tuser[1:0] == OP_DIV)
		else $error("divide status on wrong op");
`endif
endmodule
`default_nettype wire

FILE: design/fr4_divider.sv
`default_nettype none
module fr4_divider import fr4_pkg::*; #(
	parameter int W = 2 * OperandWidthDefault + 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [W-1:0] dividend,
	input wire logic [W-1:0] divisor,
	output logic busy,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	localparam int CW = $clog2(W + 1);
	logic [CW-1:0] count_q;
	logic [W-1:0] quot_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] dvs_q;
	logic [W:0] trial;
	logic [W:0] shifted;

	assign shifted = {rem_q, quot_q[W-1]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (start) begin
			count_q <= CW'(W);
		end else if (count_q != '0) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (count_q != '0) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quot_q <= {quot_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quot_q <= {quot_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy = start || (count_q != '0);
	assign quotient = quot_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

FILE: design/fr4_datapath.sv
`default_nettype none
module fr4_datapath import fr4_pkg::*; #(
	parameter int OPERAND_WIDTH = OperandWidthDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [4*FieldWidth-1:0] in_data,
	input wire ctl_t ctl,
	output sts_t sts,
	output logic negative,
	output logic [NumWidth-1:0] res_num,
	output logic [DenWidth-1:0] res_den
);
	localparam int OW = OPERAND_WIDTH;
	localparam int PW = 2 * OW;
	localparam int DW = PW + 2;

	logic [OW-1:0] a_q, b_q, c_q, d_q;
	logic an_q, bn_q, cn_q, dn_q;
	logic [PW-1:0] ad_q, bc_q, bd_q, ac_q;
	logic [DW-1:0] nm_q, dm_q, x_q, y_q;
	logic neg_q;
	logic [1:0] qphase_q;
	logic [DW-1:0] g_q;
	logic start;
	logic busy;
	logic [DW-1:0] quo, rem, dvd, dvs;
	logic [DW-1:0] sum_n;
	logic sum_neg;
	logic [DW-1:0] e_ad, e_bc;
	logic bc_neg;

	function automatic logic [OW:0] load(input logic [FieldWidth-1:0] raw);
		logic [OW-1:0] v;
		logic s;
		v = OW'(raw);
		s = v[OW-1];
		load = {s, s ? (~v + 1'b1) : v};
	endfunction

	always_ff @(posedge clk) begin
		if (ctl.cmd == DP_LOAD) begin
			{an_q, a_q} <= load(in_data[FieldWidth-1:0]);
			{bn_q, b_q} <= load(in_data[2*FieldWidth-1:FieldWidth]);
			{cn_q, c_q} <= load(in_data[3*FieldWidth-1:2*FieldWidth]);
			{dn_q, d_q} <= load(in_data[4*FieldWidth-1:3*FieldWidth]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cmd == DP_MUL) begin
			ad_q <= PW'(a_q) * PW'(d_q);
			bc_q <= PW'(b_q) * PW'(c_q);
			bd_q <= PW'(b_q) * PW'(d_q);
			ac_q <= PW'(a_q) * PW'(c_q);
		end
	end

	assign e_ad = DW'(ad_q);
	assign e_bc = DW'(bc_q);
	// Sign of the cross term bc flips for the difference.
	assign bc_neg = (bn_q ^ cn_q) ^ (ctl.op == OP_SUB);

	always_comb begin
		if ((an_q ^ dn_q) == bc_neg) begin
			sum_n = e_ad + e_bc;
			sum_neg = bc_neg;
		end else if (e_ad >= e_bc) begin
			sum_n = e_ad - e_bc;
			sum_neg = an_q ^ dn_q;
		end else begin
			sum_n = e_bc - e_ad;
			sum_neg = bc_neg;
		end
	end

	assign start = ctl.div_start;
	assign dvd = (ctl.cmd == DP_QUOT) ? ((qphase_q == 2'd0) ? nm_q : dm_q) : x_q;
	assign dvs = (ctl.cmd == DP_QUOT) ? g_q : y_q;

	fr4_divider #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(start),
		.dividend(dvd), .divisor(dvs),
		.busy(busy), .quotient(quo), .remainder(rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qphase_q <= '0;
		end else if (ctl.cmd == DP_SETUP) begin
			qphase_q <= '0;
		end else if (ctl.cmd == DP_QUOT && start) begin
			qphase_q <= qphase_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cmd == DP_SETUP) begin
			unique case (ctl.op) inside
				OP_ADD, OP_SUB: begin
					nm_q <= sum_n;
					neg_q <= sum_neg ^ bn_q ^ dn_q;
					dm_q <= DW'(bd_q);
				end
				OP_MUL: begin
					nm_q <= DW'(ac_q);
					neg_q <= an_q ^ cn_q ^ bn_q ^ dn_q;
					dm_q <= DW'(bd_q);
				end
				default: begin
					nm_q <= e_ad;
					neg_q <= an_q ^ dn_q ^ bn_q ^ cn_q;
					dm_q <= e_bc;
				end
			endcase
			x_q <= (ctl.op == OP_ADD || ctl.op == OP_SUB) ? sum_n :
				(ctl.op == OP_MUL) ? DW'(ac_q) : e_ad;
			y_q <= (ctl.op == OP_DIV) ? e_bc : DW'(bd_q);
		end else if (ctl.cmd == DP_STEP) begin
			x_q <= y_q;
			y_q <= rem;
		end else if (ctl.cmd == DP_QSTORE) begin
			if (qphase_q == 2'd1) nm_q <= quo;
			else dm_q <= quo;
		end
		if (ctl.cmd == DP_GCD) g_q <= x_q;
	end

	assign sts.den_zero = (b_q == '0) || (d_q == '0);
	assign sts.div_zero = (c_q == '0);
	assign sts.zero_num = (x_q == '0) || (y_q == '0);
	assign sts.gcd_done = (y_q == '0);
	assign sts.div_busy = busy;
	assign negative = neg_q;
	assign res_num = NumWidth'(nm_q);
	assign res_den = DenWidth'(dm_q);
endmodule
`default_nettype wire

FILE: design/fr4_controller.sv
`default_nettype none
module fr4_controller import fr4_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_fire,
	input wire logic out_free,
	input wire sts_t sts,
	output ctl_t ctl,
	output logic in_ready,
	output logic emit,
	output emit_kind_t emit_kind,
	output logic emit_last
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_MUL = 8'b00000010,
		S_CHECK = 8'b00000100,
		S_SETUP = 8'b00001000,
		S_GCD = 8'b00010000,
		S_QUOT = 8'b00100000,
		S_EMIT = 8'b01000000,
		S_WAIT = 8'b10000000
	} state_t;

	state_t state_q;
	op_t op_q;
	logic [1:0] q_q;

	// In the Euclid loop the phase counter checks for a zero value, then alternates
	// between starting a division and waiting for its remainder.
	always_comb begin
		ctl.cmd = DP_IDLE;
		ctl.op = op_q;
		ctl.div_start = 1'b0;
		unique case (state_q)
			S_IDLE: ctl.cmd = DP_LOAD;
			S_MUL: ctl.cmd = DP_MUL;
			S_SETUP: ctl.cmd = DP_SETUP;
			S_GCD: begin
				ctl.cmd = DP_GCD;
				if (q_q == 2'd1) ctl.div_start = !sts.gcd_done;
				else if (q_q == 2'd2 && !sts.div_busy) ctl.cmd = DP_STEP;
			end
			S_QUOT: begin
				ctl.cmd = DP_QUOT;
				ctl.div_start = !q_q[0];
				if (q_q[0] && !sts.div_busy) ctl.cmd = DP_QSTORE;
			end
			default: ctl.cmd = DP_IDLE;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
	assign emit = (state_q == S_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_ADD;
			q_q <= '0;
			emit_kind <= EK_NORMAL;
			emit_last <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) state_q <= S_MUL;
				S_MUL: state_q <= S_CHECK;
				S_CHECK: begin
					op_q <= OP_ADD;
					if (sts.den_zero) begin
						emit_kind <= EK_DEN_ZERO;
						emit_last <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					q_q <= '0;
					emit_last <= (op_q == OP_DIV);
					if (op_q == OP_DIV && sts.div_zero) begin
						emit_kind <= EK_DIV_ZERO;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_GCD;
					end
				end
				S_GCD: begin
					if (q_q == 2'd0) begin
						if (sts.zero_num) begin
							emit_kind <= EK_ZERO;
							state_q <= S_EMIT;
						end else begin
							q_q <= 2'd1;
						end
					end else if (q_q == 2'd1) begin
						if (sts.gcd_done) begin
							q_q <= '0;
							state_q <= S_QUOT;
						end else begin
							q_q <= 2'd2;
						end
					end else if (!sts.div_busy) begin
						q_q <= 2'd1;
					end
				end
				S_QUOT: begin
					if (!q_q[0]) begin
						q_q <= q_q + 1'b1;
					end else if (!sts.div_busy) begin
						if (q_q == 2'd1) q_q <= 2'd2;
						else begin
							emit_kind <= EK_NORMAL;
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: if (out_free) state_q <= S_WAIT;
				S_WAIT: begin
					if (emit_last) state_q <= S_IDLE;
					else begin
						op_q <= op_t'(op_q + 1'b1);
						state_q <= S_SETUP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
